// ----- sv/ppt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform package
// Shared constants, register indexes and the status bundle that travels
// alongside each transaction through the divider.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int XY_W          = 32;
    localparam int NUM_REGS      = 8;
    localparam int REG_W         = 64;
    localparam int IDX_W         = 3;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STAGES    = XY_W / BITS_PER_STEP;

    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    // Identity matrix in Q16.16.
    localparam logic [REG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW3_COLS01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW3_COLS23 = 64'h0001_0000_0000_0000;

    localparam logic [XY_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [XY_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic       valid;
        logic       w_zero;
        logic       sat;
        logic [2:0] neg;
        logic [2:0] ovf;
    } ppt_side_t;

endpackage

// ----- sv/ppt_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform multiply-accumulate
// Twelve registered 32x32 products, then floor shift and sum with the
// translation row into four wide accumulators.
// ----------------------------------------------------------------------------
module ppt_mac #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_vld,
    input  logic [ppt_pkg::XY_W-1:0]                       px,
    input  logic [ppt_pkg::XY_W-1:0]                       py,
    input  logic [ppt_pkg::XY_W-1:0]                       pz,
    input  logic [ppt_pkg::NUM_REGS-1:0][ppt_pkg::REG_W-1:0] cfg,
    output logic                                           acc_vld,
    output logic [3:0][65-FRAC_BITS:0]                     acc
);

    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int XY_W  = ppt_pkg::XY_W;

    logic [XY_W-1:0]         pt [3];
    logic signed [63:0]      prod_next [4][3];
    logic signed [63:0]      prod_reg  [4][3];
    logic [XY_W-1:0]         trans_reg [4];
    logic [3:0][ACC_W-1:0]   acc_next;
    logic [3:0][ACC_W-1:0]   acc_reg;
    logic                    vld1_reg;
    logic                    vld2_reg;

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    for (genvar gc = 0; gc < 4; gc++)
    begin : g_col
        for (genvar gr = 0; gr < 3; gr++)
        begin : g_row
            assign prod_next[gc][gr] = $signed(pt[gr])
                * $signed(cfg[gr*2 + gc/2][(gc%2)*XY_W +: XY_W]);
        end

        always_comb
        begin
            logic signed [63:0] sh;
            acc_next[gc] = ACC_W'($signed(trans_reg[gc]));
            for (int r = 0; r < 3; r++)
            begin
                sh = prod_reg[gc][r] >>> FRAC_BITS;
                acc_next[gc] = acc_next[gc] + sh[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                trans_reg[c] <= cfg[6 + c/2][(c%2)*XY_W +: XY_W];
                for (int r = 0; r < 3; r++)
                begin
                    prod_reg[c][r] <= prod_next[c][r];
                end
            end
            acc_reg <= acc_next;
        end
    end

    assign acc_vld = vld2_reg;
    assign acc     = acc_reg;

endmodule

// ----- sv/ppt_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform divider step
// Restoring division over two quotient bits, starting at TOP_BIT.
// ----------------------------------------------------------------------------
module ppt_div_step #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF,
    parameter int TOP_BIT   = ppt_pkg::XY_W - 1
) (
    input  logic [65:0]                 rem_in,
    input  logic [65-FRAC_BITS:0]       den,
    input  logic [ppt_pkg::XY_W-1:0]    quo_in,
    output logic [65:0]                 rem_out,
    output logic [ppt_pkg::XY_W-1:0]    quo_out
);

    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int CMP_W = ACC_W + ppt_pkg::XY_W;

    always_comb
    begin
        logic [CMP_W-1:0] r;
        logic [CMP_W-1:0] d;
        r       = CMP_W'(rem_in);
        quo_out = quo_in;
        for (int k = 0; k < ppt_pkg::BITS_PER_STEP; k++)
        begin
            d = CMP_W'(den) << (TOP_BIT - k);
            if (r >= d)
            begin
                r = r - d;
                quo_out[TOP_BIT - k] = 1'b1;
            end
        end
        rem_out = r[65:0];
    end

endmodule

// ----- sv/ppt_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform divider pipeline
// Three restoring dividers side by side, retiring two quotient bits
// per register stage, with the status bundle and pass values alongside.
// ----------------------------------------------------------------------------
module ppt_divider #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  ppt_pkg::ppt_side_t                  in_side,
    input  logic [2:0][65:0]                    in_num,
    input  logic [65-FRAC_BITS:0]               in_den,
    input  logic [3:0][ppt_pkg::XY_W-1:0]       in_pass,
    output ppt_pkg::ppt_side_t                  out_side,
    output logic [2:0][ppt_pkg::XY_W-1:0]       out_quo,
    output logic [3:0][ppt_pkg::XY_W-1:0]       out_pass
);

    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int NS    = ppt_pkg::DIV_STAGES;
    localparam int XY_W  = ppt_pkg::XY_W;

    ppt_pkg::ppt_side_t          side_reg [NS];
    logic [2:0][65:0]            rem_reg  [NS];
    logic [2:0][XY_W-1:0]        quo_reg  [NS];
    logic [ACC_W-1:0]            den_reg  [NS];
    logic [3:0][XY_W-1:0]        pass_reg [NS];
    logic [2:0][65:0]            rem_next [NS];
    logic [2:0][XY_W-1:0]        quo_next [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        for (genvar ch = 0; ch < 3; ch++)
        begin : g_ch
            if (s == 0)
            begin : g_first
                ppt_div_step #(
                    .FRAC_BITS (FRAC_BITS),
                    .TOP_BIT   (XY_W - 1)
                ) u_step (
                    .rem_in  (in_num[ch]),
                    .den     (in_den),
                    .quo_in  ('0),
                    .rem_out (rem_next[s][ch]),
                    .quo_out (quo_next[s][ch])
                );
            end
            else
            begin : g_rest
                ppt_div_step #(
                    .FRAC_BITS (FRAC_BITS),
                    .TOP_BIT   (XY_W - 1 - s*ppt_pkg::BITS_PER_STEP)
                ) u_step (
                    .rem_in  (rem_reg[s-1][ch]),
                    .den     (den_reg[s-1]),
                    .quo_in  (quo_reg[s-1][ch]),
                    .rem_out (rem_next[s][ch]),
                    .quo_out (quo_next[s][ch])
                );
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end

        if (s == 0)
        begin : g_load
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[s] <= '0;
                end
                else if (en)
                begin
                    side_reg[s] <= in_side;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[s]  <= in_den;
                    pass_reg[s] <= in_pass;
                end
            end
        end
        else
        begin : g_carry
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[s] <= '0;
                end
                else if (en)
                begin
                    side_reg[s] <= side_reg[s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[s]  <= den_reg[s-1];
                    pass_reg[s] <= pass_reg[s-1];
                end
            end
        end
    end

    assign out_side = side_reg[NS-1];
    assign out_quo  = quo_reg[NS-1];
    assign out_pass = pass_reg[NS-1];

endmodule

// ----- sv/projective_point_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform
// Multiplies a 3D point with an implied w of 1 by a 4x4 fixed point matrix
// and divides x, y and z by the resulting w.
// ----------------------------------------------------------------------------
// The block accepts one point per clock while the output is not stalled. Each
// result passes through the product and sum registers of the multiply and
// accumulate, the register that forms magnitudes, signs and the overflow
// test, sixteen divider stages that each retire two quotient bits of all
// three coordinates, and the output register.
// The whole pipeline advances together; an output stall while a result
// waits holds every stage and is reflected straight back to the input. The
// matrix sits in eight 64-bit registers that reset to identity and must only
// be written while no transaction is in flight.

module projective_point_transform #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ppt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ppt_pkg::REG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ppt_pkg::XY_W-1:0] in_x,
    input  logic signed [ppt_pkg::XY_W-1:0] in_y,
    input  logic signed [ppt_pkg::XY_W-1:0] in_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ppt_pkg::XY_W-1:0] out_x,
    output logic signed [ppt_pkg::XY_W-1:0] out_y,
    output logic signed [ppt_pkg::XY_W-1:0] out_z,
    output logic signed [ppt_pkg::XY_W-1:0] out_w,
    output logic                          w_was_zero,
    output logic                          saturated
);

    localparam int XY_W  = ppt_pkg::XY_W;
    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int CMP_W = ACC_W + XY_W;

    // Configuration registers, each holding two matrix elements.
    logic [ppt_pkg::NUM_REGS-1:0][ppt_pkg::REG_W-1:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[ppt_pkg::REG_ROW0_COLS01] <= ppt_pkg::RST_ROW0_COLS01;
            cfg_reg[ppt_pkg::REG_ROW0_COLS23] <= ppt_pkg::RST_ROW0_COLS23;
            cfg_reg[ppt_pkg::REG_ROW1_COLS01] <= ppt_pkg::RST_ROW1_COLS01;
            cfg_reg[ppt_pkg::REG_ROW1_COLS23] <= ppt_pkg::RST_ROW1_COLS23;
            cfg_reg[ppt_pkg::REG_ROW2_COLS01] <= ppt_pkg::RST_ROW2_COLS01;
            cfg_reg[ppt_pkg::REG_ROW2_COLS23] <= ppt_pkg::RST_ROW2_COLS23;
            cfg_reg[ppt_pkg::REG_ROW3_COLS01] <= ppt_pkg::RST_ROW3_COLS01;
            cfg_reg[ppt_pkg::REG_ROW3_COLS23] <= ppt_pkg::RST_ROW3_COLS23;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // One enable for the whole pipeline: it moves whenever the output
    // register is empty or its transaction is being taken.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Multiply and accumulate.
    logic                   acc_vld;
    logic [3:0][ACC_W-1:0]  acc;

    ppt_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .px      (in_x),
        .py      (in_y),
        .pz      (in_z),
        .cfg     (cfg_reg),
        .acc_vld (acc_vld),
        .acc     (acc)
    );

    // Preparation: saturated copies of the sums, magnitudes, quotient signs
    // and the test for a quotient that cannot fit in 32 bits.
    ppt_pkg::ppt_side_t         side_next;
    ppt_pkg::ppt_side_t         side_reg;
    logic [3:0][XY_W-1:0]       pass_next;
    logic [3:0][XY_W-1:0]       pass_reg;
    logic [2:0][NUM_W-1:0]      num_next;
    logic [2:0][NUM_W-1:0]      num_reg;
    logic [ACC_W-1:0]           den_next;
    logic [ACC_W-1:0]           den_reg;
    logic [3:0]                 clamp;

    always_comb
    begin
        logic [ACC_W-1:0] mag;
        logic             w_neg;
        side_next       = '0;
        side_next.valid = acc_vld;
        w_neg           = acc[3][ACC_W-1];
        den_next        = w_neg ? ACC_W'(-acc[3]) : acc[3];
        side_next.w_zero = (acc[3] == '0);
        for (int c = 0; c < 4; c++)
        begin
            // In range when all bits from the 32-bit sign bit upward agree.
            clamp[c] = !((acc[c][ACC_W-1:XY_W-1] == '0)
                      || (acc[c][ACC_W-1:XY_W-1] == '1));
            if (clamp[c])
            begin
                pass_next[c] = acc[c][ACC_W-1] ? ppt_pkg::Q_MIN : ppt_pkg::Q_MAX;
            end
            else
            begin
                pass_next[c] = acc[c][XY_W-1:0];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            mag = acc[c][ACC_W-1] ? ACC_W'(-acc[c]) : acc[c];
            num_next[c] = {mag, FRAC_BITS'(0)};
            side_next.neg[c] = acc[c][ACC_W-1] ^ w_neg;
            side_next.ovf[c] = CMP_W'(num_next[c]) >= {den_next, XY_W'(0)};
        end
        side_next.sat = clamp[3] || (side_next.w_zero && (clamp[0] || clamp[1] || clamp[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg        <= pass_next;
            num_reg         <= num_next;
            den_reg         <= den_next;
        end
    end

    // Divider pipeline.
    ppt_pkg::ppt_side_t     dv_side;
    logic [2:0][XY_W-1:0]   dv_quo;
    logic [3:0][XY_W-1:0]   dv_pass;

    ppt_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_side  (side_reg),
        .in_num   (num_reg),
        .in_den   (den_reg),
        .in_pass  (pass_reg),
        .out_side (dv_side),
        .out_quo  (dv_quo),
        .out_pass (dv_pass)
    );

    // Output stage: sign and clamp each quotient when w is nonzero. A
    // quotient of exactly 2^31 is representable when the result is negative.
    logic [2:0][XY_W-1:0] res_next;
    logic                 sat_next;
    logic [2:0][XY_W-1:0] res_reg;
    logic [XY_W-1:0]      w_reg;
    logic                 w_zero_reg;
    logic                 sat_reg;

    always_comb
    begin
        logic [XY_W-1:0] q;
        logic            div_sat;
        div_sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            q = dv_quo[c];
            if (dv_side.w_zero)
            begin
                res_next[c] = dv_pass[c];
            end
            else if (dv_side.ovf[c])
            begin
                res_next[c] = dv_side.neg[c] ? ppt_pkg::Q_MIN : ppt_pkg::Q_MAX;
                div_sat     = 1'b1;
            end
            else if (!dv_side.neg[c])
            begin
                if (q[XY_W-1])
                begin
                    res_next[c] = ppt_pkg::Q_MAX;
                    div_sat     = 1'b1;
                end
                else
                begin
                    res_next[c] = q;
                end
            end
            else
            begin
                if (q > ppt_pkg::Q_MIN)
                begin
                    res_next[c] = ppt_pkg::Q_MIN;
                    div_sat     = 1'b1;
                end
                else
                begin
                    res_next[c] = -q;
                end
            end
        end
        sat_next = dv_side.sat || (!dv_side.w_zero && div_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg    <= res_next;
            w_reg      <= dv_pass[3];
            w_zero_reg <= dv_side.w_zero;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = res_reg[0];
    assign out_y      = res_reg[1];
    assign out_z      = res_reg[2];
    assign out_w      = w_reg;
    assign w_was_zero = w_zero_reg;
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    // A zero w flag always goes with a zero w, and only with one: clamping
    // never turns a nonzero w into zero.
    a_wzero_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (w_was_zero == (out_w == '0)))
        else $error("w_was_zero disagrees with out_w");

    // A result that is offered but not taken stays exactly as it was.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_w) && $stable(saturated))
        else $error("result changed while held");

    // The input is only held back when a finished result waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input held back with an empty output register");
`endif

endmodule

// ----- tb/ppt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform checker
// Watches the matrix write port and both channels, predicts each transformed
// point from its own copy of the matrix and compares it with the block.
// ----------------------------------------------------------------------------
module ppt_checker #(
    parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ppt_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ppt_pkg::REG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic signed [ppt_pkg::XY_W-1:0] in_x,
    input  logic signed [ppt_pkg::XY_W-1:0] in_y,
    input  logic signed [ppt_pkg::XY_W-1:0] in_z,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [ppt_pkg::XY_W-1:0] out_x,
    input  logic signed [ppt_pkg::XY_W-1:0] out_y,
    input  logic signed [ppt_pkg::XY_W-1:0] out_z,
    input  logic signed [ppt_pkg::XY_W-1:0] out_w,
    input  logic                            w_was_zero,
    input  logic                            saturated,
    output int                              fail_count,
    output int                              pending,
    output int                              checked_count,
    output int                              wzero_count,
    output int                              sat_count
);

    localparam int XY_W     = ppt_pkg::XY_W;
    localparam int REG_W    = ppt_pkg::REG_W;
    localparam int NUM_REGS = ppt_pkg::NUM_REGS;

    typedef struct {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [XY_W-1:0] z;
        logic [XY_W-1:0] w;
        logic            wz;
        logic            sat;
    } point_result_t;

    logic [REG_W-1:0] matrix [NUM_REGS];
    point_result_t    expected_points [$];

    function automatic logic signed [XY_W-1:0] element(input int r, input int c);
        logic [REG_W-1:0] word;
        word = matrix[r * 2 + c / 2];
        return (c % 2 == 1) ? word[63:32] : word[31:0];
    endfunction

    function automatic logic [XY_W-1:0] clamp32(input logic signed [127:0] v,
                                                inout logic sat);
        if (v > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return ppt_pkg::Q_MAX;
        end
        if (v < -128'sh8000_0000) begin
            sat = 1'b1;
            return ppt_pkg::Q_MIN;
        end
        return v[XY_W-1:0];
    endfunction

    function automatic point_result_t transform(input logic signed [XY_W-1:0] px,
                                                input logic signed [XY_W-1:0] py,
                                                input logic signed [XY_W-1:0] pz);
        point_result_t      res;
        longint             acc [4];
        longint             prod;
        logic signed [XY_W-1:0] pt [3];
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic               sat;
        logic [XY_W-1:0]    q [3];
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        sat = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            acc[c] = longint'(element(3, c));
            for (int r = 0; r < 3; r++)
            begin
                prod = longint'(pt[r]) * longint'(element(r, c));
                acc[c] = acc[c] + (prod >>> FRAC_BITS);
            end
        end
        den = 128'(acc[3]);
        for (int c = 0; c < 3; c++)
        begin
            if (acc[3] != 0)
            begin
                num = 128'(acc[c]) <<< FRAC_BITS;
                q[c] = clamp32(num / den, sat);
            end
            else
                q[c] = clamp32(128'(acc[c]), sat);
        end
        res.x = q[0];
        res.y = q[1];
        res.z = q[2];
        res.w = clamp32(den, sat);
        res.wz = (acc[3] == 0);
        res.sat = sat;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [XY_W-1:0] exp_v,
                               input logic [XY_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // The matrix copy follows every write, exactly as the block's registers do.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix[ppt_pkg::REG_ROW0_COLS01] <= ppt_pkg::RST_ROW0_COLS01;
            matrix[ppt_pkg::REG_ROW0_COLS23] <= ppt_pkg::RST_ROW0_COLS23;
            matrix[ppt_pkg::REG_ROW1_COLS01] <= ppt_pkg::RST_ROW1_COLS01;
            matrix[ppt_pkg::REG_ROW1_COLS23] <= ppt_pkg::RST_ROW1_COLS23;
            matrix[ppt_pkg::REG_ROW2_COLS01] <= ppt_pkg::RST_ROW2_COLS01;
            matrix[ppt_pkg::REG_ROW2_COLS23] <= ppt_pkg::RST_ROW2_COLS23;
            matrix[ppt_pkg::REG_ROW3_COLS01] <= ppt_pkg::RST_ROW3_COLS01;
            matrix[ppt_pkg::REG_ROW3_COLS23] <= ppt_pkg::RST_ROW3_COLS23;
        end
        else if (cfg_we)
            matrix[cfg_index] <= cfg_data;
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
        checked_count = 0;
        wzero_count = 0;
        sat_count = 0;
    end

    always @(posedge clk)
    begin
        point_result_t got;
        point_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_points.push_back(transform(in_x, in_y, in_z));
            if (out_valid && !out_stall)
            begin
                got.x = out_x;
                got.y = out_y;
                got.z = out_z;
                got.w = out_w;
                got.wz = w_was_zero;
                got.sat = saturated;
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result transaction x=%h y=%h z=%h w=%h",
                             $time, got.x, got.y, got.z, got.w);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("out_w", want.w, got.w);
                    check_field("w_was_zero", 32'(want.wz), 32'(got.wz));
                    check_field("saturated", 32'(want.sat), 32'(got.sat));
                    checked_count++;
                    if (want.wz)
                        wzero_count++;
                    if (want.sat)
                        sat_count++;
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projective point transform testbench
// Drives points through the block under a series of matrices, from identity
// to projective and saturating ones, with random idling on both channels,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int XY_W     = ppt_pkg::XY_W;
    localparam int REG_W    = ppt_pkg::REG_W;
    localparam int NUM_REGS = ppt_pkg::NUM_REGS;
    localparam int IDX_W    = ppt_pkg::IDX_W;

    localparam int LATENCY   = 20;     // base of the extra waits after draining
    localparam int HOLD_LEN  = 200;    // the one long receiver hold-off
    localparam int WATCHDOG  = 5000;   // cycles without any accepted transaction

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [IDX_W-1:0]       cfg_index;
    logic [REG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [XY_W-1:0] in_x;
    logic signed [XY_W-1:0] in_y;
    logic signed [XY_W-1:0] in_z;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [XY_W-1:0] out_x;
    logic signed [XY_W-1:0] out_y;
    logic signed [XY_W-1:0] out_z;
    logic signed [XY_W-1:0] out_w;
    logic                   w_was_zero;
    logic                   saturated;

    int fail_count;
    int pending;
    int checked_count;
    int wzero_count;
    int sat_count;

    // Handshake between the stimulus and the receiver process.
    bit quiet;          // no idling at all in the closing stretch
    bit hold_request;   // ask the receiver for one long hold-off
    int sent_count;
    int matrix_count;
    int idle_cycles;

    logic [REG_W-1:0] matrix [NUM_REGS];

    projective_point_transform dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_w      (out_w),
        .w_was_zero (w_was_zero),
        .saturated  (saturated)
    );

    ppt_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_x          (in_x),
        .in_y          (in_y),
        .in_z          (in_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_w         (out_w),
        .w_was_zero    (w_was_zero),
        .saturated     (saturated),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .wzero_count   (wzero_count),
        .sat_count     (sat_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Coordinates: mostly modest values so that the division is exercised
    // properly, with full-range and boundary values mixed in.
    function automatic logic [XY_W-1:0] random_coord();
        case ($urandom_range(0, 5))
            0, 1, 2: return XY_W'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
            3:       return $urandom;
            4:       return ($urandom_range(0, 1) == 1) ? ppt_pkg::Q_MAX : ppt_pkg::Q_MIN;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
        endcase
    endfunction

    // Matrix elements: modest values, any value, or a range extreme.
    function automatic logic [XY_W-1:0] random_element(input int flavour);
        case (flavour)
            0: return XY_W'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
            1: return $urandom;
            default: return ($urandom_range(0, 1) == 1) ? ppt_pkg::Q_MAX : ppt_pkg::Q_MIN;
        endcase
    endfunction

    // A random matrix; the w column is kept small only in the modest flavour 0
    // so that w often lands near zero and the divider has real work to do.
    task automatic make_matrix(input int flavour);
        logic [XY_W-1:0] e [4][4];
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                e[r][c] = random_element(flavour);
                if (c == 3 && flavour == 0)
                    e[r][c] = XY_W'($signed($urandom_range(0, 32'h600)) - 32'sh300);
                if (c == 3 && flavour == 0 && $urandom_range(0, 3) == 0)
                    e[r][c] = 32'h0;
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            matrix[r * 2]     = {e[r][1], e[r][0]};
            matrix[r * 2 + 1] = {e[r][3], e[r][2]};
        end
    endtask

    // Registers may only change with nothing in flight.
    task automatic load_matrix();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= matrix[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        matrix_count++;
    endtask

    // Offer one point and hold it until the block takes it. Valid is left
    // high so that a following point can go out on the very next edge.
    task automatic send_point(input logic [XY_W-1:0] px, input logic [XY_W-1:0] py,
                              input logic [XY_W-1:0] pz);
        in_valid <= 1'b1;
        in_x <= px;
        in_y <= py;
        in_z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic random_points(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_point(random_coord(), random_coord(), random_coord());
            maybe_gap();
        end
        in_valid <= 1'b0;
    endtask

    // Receiver: random bursts of stall and of free flow, one long hold-off on
    // request, and no stalls at all in the closing stretch.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    // Watchdog: any long spell with no transaction on either channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("projective_point_transform: mismatch");
            $finish;
        end
    end

    initial
    begin
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_x         = '0;
        in_y         = '0;
        in_z         = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        sent_count   = 0;
        matrix_count = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points under the identity matrix left by reset: zero,
        // unit values, and both ends of the coordinate range.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_point(ppt_pkg::Q_MAX, ppt_pkg::Q_MAX, ppt_pkg::Q_MAX);
        send_point(ppt_pkg::Q_MIN, ppt_pkg::Q_MIN, ppt_pkg::Q_MIN);
        send_point(ppt_pkg::Q_MAX, ppt_pkg::Q_MIN, 32'hFFFF_FFFF);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
        in_valid <= 1'b0;

        // Only the translation row set and a zero w column: every point has
        // zero w and passes through undivided.
        for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = '0;
        matrix[ppt_pkg::REG_ROW3_COLS01] = {32'h0002_0000, 32'hFFFF_0000};
        matrix[ppt_pkg::REG_ROW3_COLS23] = {32'h0000_0000, ppt_pkg::Q_MAX};
        load_matrix();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(ppt_pkg::Q_MAX, ppt_pkg::Q_MIN, 32'h1234_5678);
        in_valid <= 1'b0;

        // w = x - 1: zero w by cancellation at x = 1, and small or negative w
        // elsewhere so that quotients overflow and saturate.
        for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = '0;
        matrix[ppt_pkg::REG_ROW0_COLS01] = {32'h0000_0000, 32'h0001_0000};
        matrix[ppt_pkg::REG_ROW0_COLS23] = {32'h0001_0000, 32'h0000_0000};
        matrix[ppt_pkg::REG_ROW1_COLS01] = {32'h0001_0000, 32'h0000_0000};
        matrix[ppt_pkg::REG_ROW2_COLS23] = {32'h0000_0000, 32'h0001_0000};
        matrix[ppt_pkg::REG_ROW3_COLS23] = {32'hFFFF_0000, 32'h0000_0000};
        load_matrix();
        send_point(32'h0001_0000, 32'h0003_0000, 32'h0005_0000);
        send_point(32'h0002_0000, 32'h0003_0000, 32'hFFFB_0000);
        send_point(32'h0001_0001, ppt_pkg::Q_MAX, ppt_pkg::Q_MIN);
        send_point(32'h0000_0000, 32'h0007_0000, 32'h0000_0001);
        send_point(ppt_pkg::Q_MAX, ppt_pkg::Q_MAX, ppt_pkg::Q_MIN);
        send_point(ppt_pkg::Q_MIN, 32'h0000_0001, 32'hFFFF_FFFF);
        in_valid <= 1'b0;

        // Every element at a range extreme: products and sums overflow.
        for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = {ppt_pkg::Q_MIN, ppt_pkg::Q_MAX};
        load_matrix();
        send_point(ppt_pkg::Q_MAX, ppt_pkg::Q_MAX, ppt_pkg::Q_MAX);
        send_point(ppt_pkg::Q_MIN, ppt_pkg::Q_MAX, ppt_pkg::Q_MIN);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        in_valid <= 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            matrix[i] = {64{1'b1}};
        load_matrix();
        send_point(32'h0001_0000, ppt_pkg::Q_MIN, ppt_pkg::Q_MAX);
        in_valid <= 1'b0;

        // Random phases, each under a freshly loaded matrix.
        for (int phase = 0; phase < 6; phase++)
        begin
            make_matrix(phase % 3 == 2 ? 1 : (phase == 4 ? 2 : 0));
            load_matrix();
            if (phase == 2)
            begin
                // Long hold-off on the output while points keep coming, so the
                // pipeline fills and the input stalls.
                hold_request = 1'b1;
                for (int i = 0; i < 60; i++)
                    send_point(random_coord(), random_coord(), random_coord());
                in_valid <= 1'b0;
                // Then pause until the block has drained completely.
                while (pending != 0)
                    @(posedge clk);
            end
            random_points(90);
        end

        // Closing stretch: modest random matrix elements, no idling anywhere.
        make_matrix(0);
        load_matrix();
        quiet = 1'b1;
        random_points(60);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Covered %0d points under %0d matrices after reset; %0d results checked.",
                 sent_count, matrix_count, checked_count);
        $display("Of those, %0d had zero w and %0d saturated.", wzero_count, sat_count);
        if (fail_count == 0 && pending == 0)
            $display("projective_point_transform: match");
        else
            $display("projective_point_transform: mismatch");
        $finish;
    end

endmodule
